### hw/rtl/iss_pkg.sv
package iss_pkg;

	localparam int KEY_FULL_W = 64;
	localparam int IDX_W      = 10;
	localparam int SWAP_W     = 20;
	localparam int SWAP_OUT_W = 19;
	localparam int HELD_W     = 11;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	localparam logic [SWAP_W-1:0]     SWAP_MAX     = {SWAP_W{1'b1}};
	localparam logic [SWAP_OUT_W-1:0] SWAP_OUT_MAX = {SWAP_OUT_W{1'b1}};
	localparam logic [HELD_W-1:0]     HELD_MAX     = {HELD_W{1'b1}};

	// command broadcast to every cell of the chain
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_LOAD,
		OP_SHIFT
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INS,
		ST_RD
	} st_t;

endpackage

### hw/rtl/iss_cell.sv
module iss_cell #(
	parameter int IDX    = 0,
	parameter int FILL_W = 11,
	parameter int KEY_W  = 64
) (
	input  logic               clk,
	input  iss_pkg::cell_op_t  op,
	input  logic [KEY_W-1:0]   new_key,
	input  logic [FILL_W-1:0]  fill,
	input  logic [KEY_W-1:0]   prev_key,
	input  logic               prev_gt,
	input  logic [KEY_W-1:0]   next_scan,
	output logic [KEY_W-1:0]   cell_key,
	output logic               gt,
	output logic [KEY_W-1:0]   scan
);

	localparam logic [FILL_W-1:0] MY_IDX = FILL_W'(IDX);

	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] scan_q;
	logic             occupied;
	logic             at_fill;

	assign occupied = MY_IDX < fill;
	assign at_fill  = MY_IDX == fill;
	assign gt       = occupied && (key_q > new_key);

	always_ff @(posedge clk) begin
		case (op)
			iss_pkg::OP_INSERT: begin
				// greater keys move up one cell, the new key lands at the boundary
				if (gt || at_fill) begin
					key_q <= prev_gt ? prev_key : new_key;
				end
				scan_q <= KEY_W'(gt);
			end
			iss_pkg::OP_LOAD: begin
				scan_q <= key_q;
			end
			iss_pkg::OP_SHIFT: begin
				scan_q <= next_scan;
			end
			default: begin
			end
		endcase
	end

	assign cell_key = key_q;
	assign scan     = scan_q;

endmodule

### hw/rtl/iss_ctrl.sv
module iss_ctrl #(
	parameter int CAPACITY = 1024,
	parameter int FILL_W   = 11,
	parameter int KEY_W    = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        kind,
	input  logic [iss_pkg::IDX_W-1:0]         read_index,
	input  logic [KEY_W-1:0]                  scan0,
	output iss_pkg::cell_op_t                 op,
	output logic [FILL_W-1:0]                 fill,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [iss_pkg::KEY_FULL_W-1:0]    read_key,
	output logic [iss_pkg::SWAP_OUT_W-1:0]    swap_total,
	output logic [iss_pkg::HELD_W-1:0]        entries_held,
	output logic                              dropped
);

	localparam int IW    = (FILL_W > iss_pkg::IDX_W) ? FILL_W : iss_pkg::IDX_W;
	localparam int EW    = (FILL_W > iss_pkg::HELD_W) ? FILL_W : iss_pkg::HELD_W;
	localparam int PAD_W = iss_pkg::KEY_FULL_W - KEY_W;
	localparam logic [FILL_W-1:0] CAP_FILL = FILL_W'(CAPACITY);

	iss_pkg::st_t state_q, state_d;

	logic [FILL_W-1:0]                 fill_q, fill_d;
	logic [iss_pkg::SWAP_W-1:0]        swap_q, swap_d;
	logic [FILL_W-1:0]                 cnt_q, cnt_d;
	logic [FILL_W-1:0]                 limit_q, limit_d;
	logic                              out_valid_q;
	logic [iss_pkg::KEY_FULL_W-1:0]    read_key_q, read_key_d;
	logic [iss_pkg::SWAP_OUT_W-1:0]    swap_total_q;
	logic [iss_pkg::HELD_W-1:0]        entries_held_q;
	logic                              dropped_q, dropped_d;

	logic                              accept;
	logic                              full;
	logic                              rd_ok;
	logic                              at_limit;
	logic                              finish;
	logic [FILL_W-1:0]                 greater;
	logic [iss_pkg::SWAP_W:0]          swap_sum;
	logic [EW-1:0]                     fill_ext;

	assign in_stall = (state_q != iss_pkg::ST_IDLE) || (out_valid_q && out_stall);
	assign accept   = (state_q == iss_pkg::ST_IDLE) && in_valid && !in_stall;
	assign full     = fill_q == CAP_FILL;
	assign rd_ok    = IW'(read_index) < IW'(fill_q);
	assign at_limit = cnt_q == limit_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			iss_pkg::ST_IDLE: begin
				if (accept) begin
					if (kind == iss_pkg::KIND_INSERT && !full) begin
						state_d = iss_pkg::ST_INS;
					end else if (kind == iss_pkg::KIND_READ && rd_ok) begin
						state_d = iss_pkg::ST_RD;
					end
				end
			end
			iss_pkg::ST_INS: begin
				if (at_limit || scan0[0]) begin
					state_d = iss_pkg::ST_IDLE;
				end
			end
			iss_pkg::ST_RD: begin
				if (at_limit) begin
					state_d = iss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = iss_pkg::ST_IDLE;
			end
		endcase
	end

	// datapath control and results
	always_comb begin
		op         = iss_pkg::OP_HOLD;
		fill_d     = fill_q;
		swap_d     = swap_q;
		cnt_d      = cnt_q;
		limit_d    = limit_q;
		finish     = 1'b0;
		read_key_d = '0;
		dropped_d  = 1'b0;
		greater    = '0;
		swap_sum   = '0;
		case (state_q)
			iss_pkg::ST_IDLE: begin
				if (accept) begin
					cnt_d = '0;
					case (kind)
						iss_pkg::KIND_INSERT: begin
							if (full) begin
								dropped_d = 1'b1;
								finish    = 1'b1;
							end else begin
								op      = iss_pkg::OP_INSERT;
								limit_d = fill_q;
								fill_d  = fill_q + FILL_W'(1);
							end
						end
						iss_pkg::KIND_READ: begin
							if (rd_ok) begin
								op      = iss_pkg::OP_LOAD;
								limit_d = FILL_W'(read_index);
							end else begin
								finish = 1'b1;
							end
						end
						iss_pkg::KIND_CLEAR: begin
							fill_d = '0;
							swap_d = '0;
							finish = 1'b1;
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end
			end
			iss_pkg::ST_INS: begin
				// flags of greater keys walk down to cell 0; the first one marks the spot
				if (at_limit || scan0[0]) begin
					greater  = at_limit ? '0 : (limit_q - cnt_q);
					swap_sum = {1'b0, swap_q} + (iss_pkg::SWAP_W + 1)'(greater);
					swap_d   = swap_sum[iss_pkg::SWAP_W] ? iss_pkg::SWAP_MAX
						: swap_sum[iss_pkg::SWAP_W-1:0];
					finish   = 1'b1;
				end else begin
					op    = iss_pkg::OP_SHIFT;
					cnt_d = cnt_q + FILL_W'(1);
				end
			end
			iss_pkg::ST_RD: begin
				if (at_limit) begin
					read_key_d = iss_pkg::KEY_FULL_W'(scan0) << PAD_W;
					finish     = 1'b1;
				end else begin
					op    = iss_pkg::OP_SHIFT;
					cnt_d = cnt_q + FILL_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign fill_ext = EW'(fill_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iss_pkg::ST_IDLE;
			fill_q      <= '0;
			swap_q      <= '0;
			cnt_q       <= '0;
			limit_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			swap_q  <= swap_d;
			cnt_q   <= cnt_d;
			limit_q <= limit_d;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			read_key_q   <= read_key_d;
			swap_total_q <= (swap_d > iss_pkg::SWAP_W'(iss_pkg::SWAP_OUT_MAX))
				? iss_pkg::SWAP_OUT_MAX : swap_d[iss_pkg::SWAP_OUT_W-1:0];
			entries_held_q <= (fill_ext > EW'(iss_pkg::HELD_MAX))
				? iss_pkg::HELD_MAX : fill_ext[iss_pkg::HELD_W-1:0];
			dropped_q    <= dropped_d;
		end
	end

	assign fill          = fill_q;
	assign out_valid     = out_valid_q;
	assign read_key      = read_key_q;
	assign swap_total    = swap_total_q;
	assign entries_held  = entries_held_q;
	assign dropped       = dropped_q;

endmodule

### hw/rtl/insertion_sort_swap_count.sv
// Sorted word store with an insertion-sort swap counter. Keys sit one per cell in a
// chain of CAPACITY cells in ascending unsigned order; an insert compares the new
// key against every cell at once and moves the greater keys up one cell in the
// same clock, so equal keys keep arrival order. The swap count of an insert (the
// number of stored keys greater than the new one) and a read by index both come
// from a scan column that walks down the chain one cell per cycle toward cell 0,
// and that walk sets the timing: an insert walks until the flag of the first
// greater key reaches cell 0 or the whole filled part is passed, a read walks
// until entry read_index reaches cell 0, and clear, unused kinds, out-of-range
// reads and refused inserts finish without a walk. One item is worked on at a
// time; the result sits in an output register, so the next item can be accepted
// as soon as the previous one is done, unless its result is still held by a stall.
// Only the top 8*KEY_BYTES bits of word_key are kept; read_key returns them with
// zero low bytes.
module insertion_sort_swap_count_core #(
	parameter int CAPACITY  = 1024,
	parameter int KEY_BYTES = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        kind,
	input  logic [iss_pkg::KEY_FULL_W-1:0]    word_key,
	input  logic [iss_pkg::IDX_W-1:0]         read_index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [iss_pkg::KEY_FULL_W-1:0]    read_key,
	output logic [iss_pkg::SWAP_OUT_W-1:0]    swap_total,
	output logic [iss_pkg::HELD_W-1:0]        entries_held,
	output logic                              dropped
);

	localparam int FILL_W = $clog2(CAPACITY + 1);
	localparam int KEY_W  = 8 * KEY_BYTES;

	iss_pkg::cell_op_t  op;
	logic [FILL_W-1:0]  fill;
	logic [KEY_W-1:0]   new_key;
	logic [KEY_W-1:0]   cell_key [CAPACITY];
	logic               gt       [CAPACITY];
	logic [KEY_W-1:0]   scan     [CAPACITY];

	assign new_key = word_key[iss_pkg::KEY_FULL_W-1 -: KEY_W];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_W-1:0] prev_key;
		logic             prev_gt;
		logic [KEY_W-1:0] next_scan;

		if (i == 0) begin : g_first
			assign prev_key = '0;
			assign prev_gt  = 1'b0;
		end else begin : g_mid
			assign prev_key = cell_key[i-1];
			assign prev_gt  = gt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_scan = '0;
		end else begin : g_inner
			assign next_scan = scan[i+1];
		end

		iss_cell #(
			.IDX    (i),
			.FILL_W (FILL_W),
			.KEY_W  (KEY_W)
		) u_cell (
			.clk       (clk),
			.op        (op),
			.new_key   (new_key),
			.fill      (fill),
			.prev_key  (prev_key),
			.prev_gt   (prev_gt),
			.next_scan (next_scan),
			.cell_key  (cell_key[i]),
			.gt        (gt[i]),
			.scan      (scan[i])
		);
	end

	iss_ctrl #(
		.CAPACITY (CAPACITY),
		.FILL_W   (FILL_W),
		.KEY_W    (KEY_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.read_index   (read_index),
		.scan0        (scan[0]),
		.op           (op),
		.fill         (fill),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_key     (read_key),
		.swap_total   (swap_total),
		.entries_held (entries_held),
		.dropped      (dropped)
	);

endmodule
